// ===== rtl/core/sbrm_pkg.sv =====
// Shared types and constants of the serial bank register mapper.
package sbrm_pkg;

  localparam logic [4:0] CONTROL_RESET = 5'h0C;
  localparam logic [4:0] PRG_MODE_FORCE = 5'h0C;
  localparam logic [7:0] BANKS_RESET = 8'd16;
  localparam logic [2:0] LOAD_LENGTH = 3'd5;

  localparam logic [1:0] QTR_CONTROL = 2'd0;
  localparam logic [1:0] QTR_CHR_LOW = 2'd1;
  localparam logic [1:0] QTR_CHR_HIGH = 2'd2;
  localparam logic [1:0] QTR_PRG = 2'd3;

  localparam logic [1:0] MIRROR_ONE_LOW = 2'd0;
  localparam logic [1:0] MIRROR_ONE_HIGH = 2'd1;
  localparam logic [1:0] MIRROR_VERTICAL = 2'd2;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd3;

  localparam logic [1:0] PRG_MODE_32K_A = 2'd0;
  localparam logic [1:0] PRG_MODE_32K_B = 2'd1;
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST = 2'd3;

  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic [4:0] control_word;
    logic [4:0] chr_select_low;
    logic [4:0] chr_select_high;
    logic [4:0] prg_select;
  } bank_regs_t;

endpackage

// ===== rtl/core/sbrm_loader.sv =====
// Serial loader and bank registers, with the state as it stands after the current item.
module sbrm_loader (
  input  logic                clk,
  input  logic                rst,
  input  logic                commit,
  input  logic                command,
  input  logic [15:0]         bus_address,
  input  logic [7:0]          write_data,
  output sbrm_pkg::bank_regs_t regs_next
);
  import sbrm_pkg::*;

  logic [4:0] load_shift;
  logic [2:0] load_count;
  bank_regs_t regs;
  logic [4:0] load_shift_next;
  logic [2:0] load_count_next;
  logic [4:0] shifted;
  logic [2:0] count_inc;

  always_comb begin
    regs_next = regs;
    load_shift_next = load_shift;
    load_count_next = load_count;
    shifted = {write_data[0], load_shift[4:1]};
    count_inc = load_count + 3'd1;
    if (command == CMD_WRITE && bus_address[15]) begin
      if (write_data[7]) begin
        load_shift_next = '0;
        load_count_next = '0;
        regs_next.control_word = regs.control_word | PRG_MODE_FORCE;
      end else if (count_inc >= LOAD_LENGTH) begin
        load_shift_next = '0;
        load_count_next = '0;
        case (bus_address[14:13])
          QTR_CONTROL:  regs_next.control_word = shifted;
          QTR_CHR_LOW:  regs_next.chr_select_low = shifted;
          QTR_CHR_HIGH: regs_next.chr_select_high = shifted;
          default:      regs_next.prg_select = shifted;
        endcase
      end else begin
        load_shift_next = shifted;
        load_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_shift <= '0;
      load_count <= '0;
      regs.control_word <= CONTROL_RESET;
      regs.chr_select_low <= '0;
      regs.chr_select_high <= '0;
      regs.prg_select <= '0;
    end else if (commit) begin
      load_shift <= load_shift_next;
      load_count <= load_count_next;
      regs <= regs_next;
    end
  end

endmodule

// ===== rtl/core/sbrm_translate.sv =====
// Address translation for CHR, nametable, PRG RAM and PRG ROM windows; other addresses below 0x6000 pass through.
module sbrm_translate (
  input  logic                 [15:0] bus_address,
  input  sbrm_pkg::bank_regs_t        regs,
  input  logic                 [7:0]  prg_rom_banks,
  output logic                 [21:0] bank_offset
);
  import sbrm_pkg::*;

  logic [15:0] a;
  logic [1:0]  prg_mode;
  logic [7:0]  last_bank;

  assign a = bus_address;
  assign prg_mode = regs.control_word[3:2];
  assign last_bank = prg_rom_banks - 8'd1;

  always_comb begin
    bank_offset = '0;
    if (a < 16'h2000) begin
      if (regs.control_word[4]) begin
        if (!a[12]) begin
          bank_offset = {5'd0, regs.chr_select_low, a[11:0]};
        end else begin
          bank_offset = {5'd0, regs.chr_select_high, a[11:0]};
        end
      end else begin
        bank_offset = {5'd0, regs.chr_select_low[4:1], a[12:0]};
      end
    end else if (a < 16'h3F00) begin
      case (regs.control_word[1:0])
        MIRROR_ONE_LOW:  bank_offset = {12'd0, a[9:0]};
        MIRROR_ONE_HIGH: bank_offset = {11'd0, 1'b1, a[9:0]};
        MIRROR_VERTICAL: bank_offset = {11'd0, a[10:0]};
        default:         bank_offset = {11'd0, a[11], a[9:0]};
      endcase
    end else if (a < 16'h6000) begin
      bank_offset = {6'd0, a};
    end else if (!a[15]) begin
      bank_offset = {9'd0, a[12:0]};
    end else begin
      case (prg_mode)
        PRG_MODE_32K_A, PRG_MODE_32K_B: begin
          bank_offset = {4'd0, regs.prg_select[3:1], a[14:0]};
        end
        PRG_MODE_FIX_FIRST: begin
          if (!a[14]) begin
            bank_offset = {8'd0, a[13:0]};
          end else begin
            bank_offset = {4'd0, regs.prg_select[3:0], a[13:0]};
          end
        end
        default: begin
          if (!a[14]) begin
            bank_offset = {4'd0, regs.prg_select[3:0], a[13:0]};
          end else begin
            bank_offset = {last_bank, a[13:0]};
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/serial_bank_register_mapper.sv =====
// Top level of the serial bank register mapper: input stage, loader, translation, result stage.
// An accepted item is registered into the input stage, then into the result stage.
// Throughput: one item per cycle unless stalled; loader and translation share one stage.
// The input stage stalls only while a finished result waits and the output is stalled.
// Reset is synchronous: loader clear, control word 0x0C, bank registers zero, 16 PRG banks.
module serial_bank_register_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        config_write,
  input  logic [7:0]  config_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [21:0] bank_offset
);
  import sbrm_pkg::*;

  logic        s1_valid;
  logic        s1_command;
  logic [15:0] s1_address;
  logic [7:0]  s1_data;
  logic [7:0]  prg_rom_banks;
  logic        accept;
  logic        advance;
  bank_regs_t  regs_next;
  logic [21:0] mapped_next;

  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept = in_valid && !in_stall;
  assign advance = s1_valid && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      prg_rom_banks <= BANKS_RESET;
    end else begin
      if (config_write) begin
        prg_rom_banks <= config_data;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_command <= command;
      s1_address <= bus_address;
      s1_data <= write_data;
    end
    if (advance) begin
      bank_offset <= mapped_next;
    end
  end

  sbrm_loader u_loader (
    .clk         (clk),
    .rst         (rst),
    .commit      (advance),
    .command     (s1_command),
    .bus_address (s1_address),
    .write_data  (s1_data),
    .regs_next   (regs_next)
  );

  sbrm_translate u_translate (
    .bus_address   (s1_address),
    .regs          (regs_next),
    .prg_rom_banks (prg_rom_banks),
    .bank_offset   (mapped_next)
  );

endmodule
